[rtl/core/dtavg_pkg.sv]
`default_nettype none

package dtavg_pkg;

  localparam int INT_DIGITS  = 9;
  localparam int FRAC_DIGITS = 4;
  localparam int COUNT_BITS  = 16;

  localparam int CH_W       = 8;
  localparam int AVG_W      = 45;
  localparam int CNT_W      = 16;
  localparam int MAG_W      = 44;
  localparam int SUM_W      = 62;
  localparam int INT_CNT_W  = $clog2(INT_DIGITS + 2);
  localparam int FRAC_CNT_W = $clog2(FRAC_DIGITS + 2);
  localparam int POW_W      = $clog2(10 ** FRAC_DIGITS + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_MINUS,
    CLS_POINT,
    CLS_SEP,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic [CNT_W-1:0]        count;
    logic                    overflow;
  } out_item_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } tok_item_t;

  typedef struct packed {
    logic running;
    logic dividing;
    logic finishing;
  } back_stat_t;

  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] idx);
    logic [POW_W-1:0] p;
    case (int'(idx))
      0:       p = POW_W'(64'd1);
      1:       p = POW_W'(64'd10);
      2:       p = POW_W'(64'd100);
      3:       p = POW_W'(64'd1000);
      4:       p = POW_W'(64'd10000);
      5:       p = POW_W'(64'd100000);
      6:       p = POW_W'(64'd1000000);
      default: p = POW_W'(64'd1);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dtavg_front.sv]
`default_nettype none

module dtavg_front (
  input  wire logic                 byte_valid,
  input  wire dtavg_pkg::in_item_t  byte_data,
  output logic                      byte_stall,
  input  wire logic                 fifo_full,
  output logic                      push,
  output dtavg_pkg::tok_item_t      item
);
  import dtavg_pkg::*;

  assign byte_stall = fifo_full;
  assign push       = byte_valid && !fifo_full;

  always_comb begin
    item.last  = byte_data.last;
    item.digit = 4'(byte_data.ch - CH_ZERO);
    if (byte_data.ch >= CH_ZERO && byte_data.ch <= CH_NINE) begin
      item.cls = CLS_DIGIT;
    end else if (byte_data.ch == CH_MINUS) begin
      item.cls = CLS_MINUS;
    end else if (byte_data.ch == CH_POINT || byte_data.ch == CH_COMMA) begin
      item.cls = CLS_POINT;
    end else if (byte_data.ch == CH_SPACE || byte_data.ch == CH_LF) begin
      item.cls = CLS_SEP;
    end else begin
      item.cls = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtavg_fifo.sv]
`default_nettype none

module dtavg_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire dtavg_pkg::tok_item_t  wr_item,
  input  wire logic                  pop,
  output dtavg_pkg::tok_item_t       rd_item,
  output logic                       full,
  output logic                       empty
);
  import dtavg_pkg::*;

  tok_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   fill;

  assign full    = (fill == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtavg_div.sv]
`default_nettype none

module dtavg_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [dtavg_pkg::SUM_W-1:0]      dividend,
  input  wire logic [dtavg_pkg::COUNT_BITS-1:0] divisor,
  output logic                                  done,
  output logic [dtavg_pkg::SUM_W-1:0]           quotient
);
  import dtavg_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS-1:0] dsr;
  logic [COUNT_BITS-1:0] rem;
  logic [SUM_W-1:0]      q;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   trial;

  assign shifted  = {rem, q[SUM_W-1]};
  assign trial    = shifted - {1'b0, dsr};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[COUNT_BITS]) begin
        rem <= trial[COUNT_BITS-1:0];
        q   <= {q[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[COUNT_BITS-1:0];
        q   <= {q[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtavg_back.sv]
`default_nettype none

module dtavg_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fifo_empty,
  input  wire dtavg_pkg::tok_item_t        head,
  output logic                             pop,
  output logic                             div_start,
  output logic [dtavg_pkg::SUM_W-1:0]      div_dividend,
  output logic [dtavg_pkg::COUNT_BITS-1:0] div_divisor,
  input  wire logic                        div_done,
  input  wire logic [dtavg_pkg::SUM_W-1:0] div_quotient,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output dtavg_pkg::out_item_t             result_data,
  output dtavg_pkg::back_stat_t            stat
);
  import dtavg_pkg::*;

  typedef enum logic [5:0] {
    ST_RUN    = 6'b000001,
    ST_FLUSH  = 6'b000010,
    ST_SETTLE = 6'b000100,
    ST_LOAD   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } back_state_t;

  back_state_t           state, state_next;
  logic                  started, started_next;
  logic                  neg, neg_next;
  logic                  bad, bad_next;
  logic                  seen_point, seen_point_next;
  logic                  last_dig, last_dig_next;
  logic [MAG_W-1:0]      mag, mag_next;
  logic [INT_CNT_W-1:0]  int_cnt, int_cnt_next;
  logic [FRAC_CNT_W-1:0] frac_cnt, frac_cnt_next;
  logic [MAG_W-1:0]      prod, prod_next;
  logic                  prod_neg, prod_neg_next;
  logic                  prod_valid, prod_valid_next;
  logic [SUM_W-1:0]      sum, sum_next;
  logic [COUNT_BITS-1:0] vcount, vcount_next;
  logic                  ovf, ovf_next;
  logic                  sum_neg, sum_neg_next;
  logic                  cnt_zero, cnt_zero_next;
  logic                  result_valid_next;
  out_item_t             result_data_next;

  logic [MAG_W-1:0]      dig_mag;
  logic [INT_CNT_W-1:0]  dig_int;
  logic [FRAC_CNT_W-1:0] dig_frac;
  logic                  do_close;
  logic                  close_hit;
  logic                  clear_all;
  logic [AVG_W-1:0]      q_avg;

  assign stat.running   = (state == ST_RUN);
  assign stat.dividing  = (state == ST_DIV);
  assign stat.finishing = (state == ST_DONE);

  assign div_dividend = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  assign div_divisor  = vcount;
  assign q_avg        = AVG_W'(div_quotient);
  assign close_hit    = started && !bad && last_dig;

  // digit path of the current token
  always_comb begin
    dig_mag  = mag;
    dig_int  = int_cnt;
    dig_frac = frac_cnt;
    if (!seen_point) begin
      if (!(mag == '0 && head.digit == '0) && int_cnt <= INT_CNT_W'(INT_DIGITS)) begin
        dig_int = int_cnt + 1'b1;
        if (int_cnt < INT_CNT_W'(INT_DIGITS)) begin
          dig_mag = MAG_W'(mag * 4'd10) + MAG_W'(head.digit);
        end
      end
    end else if (frac_cnt < FRAC_CNT_W'(FRAC_DIGITS)) begin
      dig_mag  = MAG_W'(mag * 4'd10) + MAG_W'(head.digit);
      dig_frac = frac_cnt + 1'b1;
    end
  end

  always_comb begin
    state_next        = state;
    started_next      = started;
    neg_next          = neg;
    bad_next          = bad;
    seen_point_next   = seen_point;
    last_dig_next     = last_dig;
    mag_next          = mag;
    int_cnt_next      = int_cnt;
    frac_cnt_next     = frac_cnt;
    prod_next         = prod;
    prod_neg_next     = prod_neg;
    prod_valid_next   = 1'b0;
    vcount_next       = vcount;
    ovf_next          = ovf;
    sum_neg_next      = sum_neg;
    cnt_zero_next     = cnt_zero;
    result_valid_next = result_valid && result_stall;
    result_data_next  = result_data;
    pop               = 1'b0;
    div_start         = 1'b0;
    do_close          = 1'b0;
    clear_all         = 1'b0;

    if (prod_valid) begin
      sum_next = prod_neg ? (sum - SUM_W'(prod)) : (sum + SUM_W'(prod));
    end else begin
      sum_next = sum;
    end

    case (state)
      ST_RUN: begin
        if (!fifo_empty) begin
          pop = 1'b1;
          if (head.cls == CLS_SEP) begin
            do_close = 1'b1;
          end else if (!started) begin
            started_next = 1'b1;
            if (head.cls == CLS_MINUS) begin
              neg_next      = 1'b1;
              last_dig_next = 1'b0;
            end else if (head.cls == CLS_DIGIT) begin
              last_dig_next = 1'b1;
              mag_next      = dig_mag;
              int_cnt_next  = dig_int;
              frac_cnt_next = dig_frac;
            end else begin
              bad_next      = 1'b1;
              last_dig_next = 1'b0;
            end
          end else if (head.cls == CLS_DIGIT) begin
            last_dig_next = 1'b1;
            mag_next      = dig_mag;
            int_cnt_next  = dig_int;
            frac_cnt_next = dig_frac;
          end else if (head.cls == CLS_POINT) begin
            if (seen_point) begin
              bad_next = 1'b1;
            end
            seen_point_next = 1'b1;
            last_dig_next   = 1'b0;
          end else begin
            bad_next      = 1'b1;
            last_dig_next = 1'b0;
          end
          if (head.last) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        do_close   = 1'b1;
        state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        sum_neg_next  = sum[SUM_W-1];
        cnt_zero_next = (vcount == '0);
        if (vcount == '0) begin
          state_next = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          result_valid_next         = 1'b1;
          result_data_next.count    = CNT_W'(vcount);
          result_data_next.overflow = ovf;
          if (cnt_zero) begin
            result_data_next.average = '0;
          end else if (sum_neg) begin
            result_data_next.average = ~q_avg + 1'b1;
          end else begin
            result_data_next.average = q_avg;
          end
          clear_all  = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase

    if (do_close) begin
      if (close_hit) begin
        if (int_cnt > INT_CNT_W'(INT_DIGITS) || vcount == '1) begin
          ovf_next = 1'b1;
        end else begin
          prod_next       = MAG_W'(mag * pow10(FRAC_CNT_W'(FRAC_DIGITS) - frac_cnt));
          prod_neg_next   = neg;
          prod_valid_next = 1'b1;
          vcount_next     = vcount + 1'b1;
        end
      end
    end

    if (do_close || clear_all) begin
      started_next    = 1'b0;
      neg_next        = 1'b0;
      bad_next        = 1'b0;
      seen_point_next = 1'b0;
      last_dig_next   = 1'b0;
      mag_next        = '0;
      int_cnt_next    = '0;
      frac_cnt_next   = '0;
    end

    if (clear_all) begin
      sum_next        = '0;
      vcount_next     = '0;
      ovf_next        = 1'b0;
      prod_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod        <= prod_next;
    prod_neg    <= prod_neg_next;
    sum_neg     <= sum_neg_next;
    cnt_zero    <= cnt_zero_next;
    result_data <= result_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      started      <= 1'b0;
      neg          <= 1'b0;
      bad          <= 1'b0;
      seen_point   <= 1'b0;
      last_dig     <= 1'b0;
      mag          <= '0;
      int_cnt      <= '0;
      frac_cnt     <= '0;
      prod_valid   <= 1'b0;
      sum          <= '0;
      vcount       <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      started      <= started_next;
      neg          <= neg_next;
      bad          <= bad_next;
      seen_point   <= seen_point_next;
      last_dig     <= last_dig_next;
      mag          <= mag_next;
      int_cnt      <= int_cnt_next;
      frac_cnt     <= frac_cnt_next;
      prod_valid   <= prod_valid_next;
      sum          <= sum_next;
      vcount       <= vcount_next;
      ovf          <= ovf_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/decimal_token_average_unit.sv]
// throughput: one byte per cycle; the four-entry front queue takes bytes while a result is built, then stalls
// path: each transferred byte is registered in the front queue and reaches the token parser from the queue head
// result: after the last byte the parser passes flush, settle and load, then the 62-step bit-serial divider, then done
// a stream with no valid token skips the divider and goes from load straight to done
// reset: synchronous, clears the queue, token state, sum, count, overflow flag and result valid
`default_nettype none

module decimal_token_average_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire dtavg_pkg::in_item_t  byte_data,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output dtavg_pkg::out_item_t      result_data
);
  import dtavg_pkg::*;

  tok_item_t             wr_item;
  tok_item_t             head;
  logic                  push;
  logic                  pop;
  logic                  fifo_full;
  logic                  fifo_empty;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic [SUM_W-1:0]      div_quotient;
  back_stat_t            stat;

  dtavg_front u_front (
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_stall (byte_stall),
    .fifo_full  (fifo_full),
    .push       (push),
    .item       (wr_item)
  );

  dtavg_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (head),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  dtavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  dtavg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_empty   (fifo_empty),
    .head         (head),
    .pop          (pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .stat         (stat)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !fifo_empty)
    else $error("queue popped while empty");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst) div_done |-> stat.dividing)
    else $error("divider finished outside the divide state");
  a_start_leaves_run: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !stat.running)
    else $error("parser resumed while the divider runs");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stat.finishing))
    else $error("result raised outside the finishing state");
`endif

endmodule

`default_nettype wire
